[rtl/core/spt_pkg.sv]
package spt_pkg;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned STEP_W  = 15;
  localparam int unsigned OUTJ_W  = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned SIT_JOINTS = 12;
  localparam int unsigned RATIO_W = 16;

  localparam logic [TICK_W-1:0] TICK_MAX         = 16'hFFFF;
  localparam logic [TICK_W-1:0] TRANSITION_RESET = 16'd100;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET    = 16'd25;
  localparam logic [STEP_W-1:0] MAX_STEP_RESET   = 15'd82;
  // 3.0 in Q2.16, two bits wider than the ratio to hold 3 - 2r
  localparam logic [RATIO_W+1:0] THREE_Q16       = 18'd196608;

  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_MODE     = 2'd1,
    FUNC_FEEDBACK = 2'd2,
    FUNC_NONE     = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIT_0_3      = 3'd0,
    CFG_SIT_4_7      = 3'd1,
    CFG_SIT_8_11     = 3'd2,
    CFG_TRANSITION   = 3'd3,
    CFG_TIMEOUT      = 3'd4,
    CFG_MAX_STEP     = 3'd5,
    CFG_RSVD6        = 3'd6,
    CFG_RSVD7        = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TMODE_SOURCE = 2'd0,
    TMODE_SIT    = 2'd1,
    TMODE_BLEND  = 2'd2
  } tick_mode_e;

  typedef struct packed {
    logic mode_upd;
    logic fb_wr;
    logic tick_start;
    logic div_step;
    logic square;
    logic cube;
    logic prod;
    logic emit;
    logic tick_end;
  } spt_cmd_t;

  typedef struct packed {
    logic blend;
    logic out_free;
  } spt_sts_t;

endpackage

[rtl/core/spt_ctrl.sv]
module spt_ctrl import spt_pkg::*; #(
  parameter int unsigned JOINT_COUNT = 12,
  parameter int unsigned JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    in_func_i,
  output logic          in_ready_o,
  input  spt_sts_t      sts_i,
  output spt_cmd_t      cmd_o,
  output logic [JW-1:0] joint_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_DIV, S_SQ, S_CUBE, S_PROD, S_EMIT
  } state_e;

  localparam logic [JW-1:0] LAST_J = JW'(JOINT_COUNT - 1);

  state_e        state_q, state_d;
  logic [3:0]    cnt_q, cnt_d;
  logic [JW-1:0] joint_q, joint_d;
  logic          accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign joint_o    = joint_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    joint_d = joint_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (func_e'(in_func_i))
            FUNC_TICK: begin
              cmd_o.tick_start = 1'b1;
              state_d = S_DECIDE;
            end
            FUNC_MODE:     cmd_o.mode_upd = 1'b1;
            FUNC_FEEDBACK: cmd_o.fb_wr = 1'b1;
            default: ;
          endcase
        end
      end
      S_DECIDE: begin
        cnt_d   = '0;
        joint_d = '0;
        state_d = sts_i.blend ? S_DIV : S_PROD;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) state_d = S_SQ;
      end
      S_SQ: begin
        cmd_o.square = 1'b1;
        state_d = S_CUBE;
      end
      S_CUBE: begin
        cmd_o.cube = 1'b1;
        state_d = S_PROD;
      end
      S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (joint_q == LAST_J) begin
            cmd_o.tick_end = 1'b1;
            state_d = S_IDLE;
          end else begin
            joint_d = joint_q + JW'(1);
            state_d = S_PROD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      joint_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      joint_q <= joint_d;
    end
  end

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == 4'd15) |=> state_q == S_SQ)
    else $error("divider did not run sixteen steps");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && sts_i.out_free && joint_q == LAST_J) |=> state_q == S_IDLE)
    else $error("tick did not end after last joint");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result loaded into busy output register");

endmodule

[rtl/core/spt_datapath.sv]
module spt_datapath import spt_pkg::*; #(
  parameter int unsigned JOINT_COUNT = 12,
  parameter int unsigned JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spt_cmd_t              cmd_i,
  input  logic [JW-1:0]         joint_i,
  output spt_sts_t              sts_o,
  input  logic                  in_sit_i,
  input  logic [3:0]            in_joint_i,
  input  logic [ANGLE_W-1:0]    in_pos_i,
  input  logic                  cfg_wr_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUTJ_W-1:0]     out_joint_o,
  output logic [ANGLE_W-1:0]    out_angle_o,
  output logic [STEP_W-1:0]     out_step_o,
  output logic [SEQ_W-1:0]      out_seq_o,
  output logic                  out_last_o
);

  logic [CFG_W-1:0]   sit_q [3];
  logic [TICK_W-1:0]  trans_q, timeout_q;
  logic [STEP_W-1:0]  max_step_q;

  logic               sit_act_q, blend_q, fb_valid_q;
  logic [TICK_W-1:0]  elapsed_q, age_q;
  logic [SEQ_W-1:0]   seq_q;
  tick_mode_e         mode_q;
  logic [ANGLE_W-1:0] start_q [JOINT_COUNT];
  logic [ANGLE_W-1:0] pub_q   [JOINT_COUNT];
  logic [ANGLE_W-1:0] fb_q    [JOINT_COUNT];

  logic [RATIO_W-1:0] rem_q, quo_q, s_q;
  logic [2*RATIO_W-1:0] sq_q;
  logic signed [2*ANGLE_W+1:0] prod_q;

  logic               fresh, fb_hit;
  logic [TICK_W-1:0]  e_next;
  logic [RATIO_W:0]   div_sh;
  logic               div_ge;
  logic [RATIO_W+1:0] k_fac;
  logic [3*RATIO_W+1:0] cube_p;
  logic [ANGLE_W-1:0] sit_ang, start_j, target;
  logic [3:0]         jn;
  logic [CFG_W-1:0]   sit_word;
  logic signed [ANGLE_W:0] diff;
  logic [ANGLE_W+1:0] blend_sum;
  logic [JW-1:0]      fb_idx;

  assign fresh   = fb_valid_q && (age_q <= timeout_q);
  assign fb_idx  = JW'(in_joint_i);
  assign fb_hit  = (32'(in_joint_i) < JOINT_COUNT);
  assign e_next  = (elapsed_q != TICK_MAX) ? elapsed_q + 16'd1 : elapsed_q;
  assign div_sh  = {rem_q, 1'b0};
  assign div_ge  = div_sh >= {1'b0, trans_q};
  assign k_fac   = THREE_Q16 - {1'b0, quo_q, 1'b0};
  assign cube_p  = sq_q * k_fac;
  assign start_j = start_q[joint_i];

  // sit angle of the current joint; joints past the configured twelve sit at zero
  always_comb begin
    jn = 4'(joint_i);
    sit_word = '0;
    sit_ang  = '0;
    if (32'(joint_i) < SIT_JOINTS) begin
      case (jn[3:2])
        2'd0:    sit_word = sit_q[0];
        2'd1:    sit_word = sit_q[1];
        default: sit_word = sit_q[2];
      endcase
      sit_ang = sit_word[ANGLE_W*jn[1:0] +: ANGLE_W];
    end
  end

  assign diff      = $signed({sit_ang[ANGLE_W-1], sit_ang})
                   - $signed({start_j[ANGLE_W-1], start_j});
  assign blend_sum = {{2{start_j[ANGLE_W-1]}}, start_j} + prod_q[2*ANGLE_W+1:RATIO_W];

  always_comb begin
    case (mode_q)
      TMODE_SOURCE: target = fresh ? fb_q[joint_i] : pub_q[joint_i];
      TMODE_SIT:    target = sit_ang;
      default:      target = blend_sum[ANGLE_W-1:0];
    endcase
  end

  assign sts_o.blend    = (mode_q == TMODE_BLEND);
  assign sts_o.out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) sit_q[i] <= '0;
      trans_q    <= TRANSITION_RESET;
      timeout_q  <= TIMEOUT_RESET;
      max_step_q <= MAX_STEP_RESET;
      sit_act_q  <= 1'b0;
      blend_q    <= 1'b0;
      fb_valid_q <= 1'b0;
      elapsed_q  <= '0;
      age_q      <= '0;
      seq_q      <= '0;
      mode_q     <= TMODE_SOURCE;
      out_valid_o <= 1'b0;
      for (int i = 0; i < JOINT_COUNT; i++) begin
        start_q[i] <= '0;
        pub_q[i]   <= '0;
      end
    end else begin
      if (cfg_wr_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_SIT_0_3:    sit_q[0]   <= cfg_data_i;
          CFG_SIT_4_7:    sit_q[1]   <= cfg_data_i;
          CFG_SIT_8_11:   sit_q[2]   <= cfg_data_i;
          CFG_TRANSITION: trans_q    <= cfg_data_i[TICK_W-1:0];
          CFG_TIMEOUT:    timeout_q  <= cfg_data_i[TICK_W-1:0];
          CFG_MAX_STEP:   max_step_q <= cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.mode_upd) begin
        if (in_sit_i && !sit_act_q) begin
          sit_act_q <= 1'b1;
          blend_q   <= 1'b1;
          elapsed_q <= '0;
          for (int i = 0; i < JOINT_COUNT; i++)
            start_q[i] <= fresh ? fb_q[i] : pub_q[i];
        end else if (!in_sit_i && sit_act_q) begin
          sit_act_q <= 1'b0;
          blend_q   <= 1'b0;
        end
      end
      if (cmd_i.fb_wr && fb_hit && 32'(in_joint_i) == JOINT_COUNT - 1) begin
        fb_valid_q <= 1'b1;
        age_q      <= '0;
      end
      if (cmd_i.tick_start) begin
        if (!sit_act_q) begin
          mode_q <= TMODE_SOURCE;
        end else if (!blend_q) begin
          mode_q <= TMODE_SIT;
        end else begin
          elapsed_q <= e_next;
          if (trans_q == '0 || e_next >= trans_q) begin
            blend_q <= 1'b0;
            mode_q  <= TMODE_SIT;
          end else begin
            mode_q <= TMODE_BLEND;
          end
        end
      end
      if (cmd_i.emit) begin
        out_valid_o     <= 1'b1;
        pub_q[joint_i]  <= target;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (cmd_i.tick_end) begin
        seq_q <= seq_q + 16'd1;
        if (age_q != TICK_MAX) age_q <= age_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fb_wr && fb_hit) fb_q[fb_idx] <= in_pos_i;
    if (cmd_i.tick_start) begin
      rem_q <= e_next;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? RATIO_W'(div_sh - {1'b0, trans_q}) : div_sh[RATIO_W-1:0];
      quo_q <= {quo_q[RATIO_W-2:0], div_ge};
    end
    if (cmd_i.square) sq_q <= quo_q * quo_q;
    if (cmd_i.cube)   s_q  <= cube_p[3*RATIO_W-1:2*RATIO_W];
    if (cmd_i.prod)   prod_q <= diff * $signed({1'b0, s_q});
    if (cmd_i.emit) begin
      out_joint_o <= OUTJ_W'(joint_i);
      out_angle_o <= target;
      out_step_o  <= max_step_q;
      out_seq_o   <= seq_q;
      out_last_o  <= (32'(joint_i) == JOINT_COUNT - 1);
    end
  end

  a_blend_sit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blend_q |-> sit_act_q)
    else $error("blend running without sit request");

endmodule

[rtl/core/smoothstep_pose_transition_core.sv]
// A tick runs from accept through a decide state to the per-joint product and emit states;
// with a blend it first runs a 16-step divider plus two multiply stages (square, cube).
// Each emit waits while the output register is busy; no new request is taken until the
// tick ends. Mode and feedback requests are taken in idle without leaving it.
// Reset (async, active low) clears poses, flags, counters and loads register
// defaults; feedback angles keep no reset value until written.
module smoothstep_pose_transition_core import spt_pkg::*; #(
  parameter int unsigned JOINT_COUNT = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // sit_requested, joint[3:0], position[15:0]
  input  logic [1:0]  s_axis_tuser_i,  // func[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,  // out_joint, target_angle, step_limit, sequence_res
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

  spt_cmd_t      cmd;
  spt_sts_t      sts;
  logic [JW-1:0] joint;

  assign cfg_ready_o = 1'b1;
  assign m_axis_tdata_o[55:51] = '0;

  spt_ctrl #(.JOINT_COUNT(JOINT_COUNT), .JW(JW)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_func_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .joint_o    (joint)
  );

  spt_datapath #(.JOINT_COUNT(JOINT_COUNT), .JW(JW)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .joint_i     (joint),
    .sts_o       (sts),
    .in_sit_i    (s_axis_tdata_i[0]),
    .in_joint_i  (s_axis_tdata_i[4:1]),
    .in_pos_i    (s_axis_tdata_i[20:5]),
    .cfg_wr_i    (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i   (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_joint_o (m_axis_tdata_o[3:0]),
    .out_angle_o (m_axis_tdata_o[19:4]),
    .out_step_o  (m_axis_tdata_o[34:20]),
    .out_seq_o   (m_axis_tdata_o[50:35]),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

[sim/tb_smoothstep_pose_transition_core.sv]
`timescale 1ns / 1ps

module tb_smoothstep_pose_transition_core;
  import spt_pkg::*;

  typedef struct {
    logic [3:0]  jn;
    logic [15:0] angle;
    logic [14:0] step;
    logic [15:0] seq;
    logic        last;
  } target_t;

  typedef struct {
    func_e       f;
    bit          sit;
    bit [3:0]    jn;
    bit [15:0]   pos;
    bit          chk;
    bit [15:0]   angle;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  smoothstep_pose_transition_core dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [63:0]        sit_word[3];
  int unsigned        blend_len, fresh_limit;
  logic [14:0]        step_cap;
  bit                 sit_on, blending;
  int unsigned        elapsed, fb_age;
  logic [15:0]        tick_seq;
  logic signed [15:0] start_pose[12], pub_pose[12], fb_pose[12];
  bit                 fb_ok;

  target_t     pending_targets[$];
  int          mismatches = 0;
  int          n_results = 0, n_ticks = 0, n_items = 0, n_blend = 0;
  int          quiet = 0;
  int unsigned send_idle_pct = 0, recv_idle_pct = 0;

  function automatic logic signed [15:0] sit_angle(int j);
    return sit_word[j / 4][16 * (j % 4) +: 16];
  endfunction

  function automatic void apply_request(func_e f, bit sit, bit [3:0] jn, bit [15:0] pos,
                                        bit chk, bit [15:0] angle);
    logic signed [15:0] tgt[12];
    longint unsigned r, s;
    longint prod;
    bit fresh;
    target_t t;
    fresh = fb_ok && (fb_age <= fresh_limit);
    case (f)
      FUNC_MODE: begin
        if (sit && !sit_on) begin
          sit_on = 1;
          for (int j = 0; j < 12; j++) start_pose[j] = fresh ? fb_pose[j] : pub_pose[j];
          elapsed = 0;
          blending = 1;
        end else if (!sit && sit_on) begin
          sit_on = 0;
          blending = 0;
        end
      end
      FUNC_FEEDBACK: begin
        if (jn < 12) begin
          fb_pose[jn] = pos;
          if (jn == 11) begin
            fb_ok = 1;
            fb_age = 0;
          end
        end
      end
      FUNC_TICK: begin
        if (!sit_on) begin
          for (int j = 0; j < 12; j++) tgt[j] = fresh ? fb_pose[j] : pub_pose[j];
        end else if (!blending) begin
          for (int j = 0; j < 12; j++) tgt[j] = sit_angle(j);
        end else begin
          if (elapsed < 16'hFFFF) elapsed++;
          if (blend_len == 0 || elapsed >= blend_len) begin
            blending = 0;
            for (int j = 0; j < 12; j++) tgt[j] = sit_angle(j);
          end else begin
            n_blend++;
            r = (longint'(elapsed) << 16) / blend_len;
            s = (r * r * (196608 - 2 * r)) >> 32;
            for (int j = 0; j < 12; j++) begin
              prod = (longint'(sit_angle(j)) - longint'(start_pose[j])) * longint'(s);
              tgt[j] = 16'(longint'(start_pose[j]) + (prod >>> 16));
            end
          end
        end
        for (int j = 0; j < 12; j++) begin
          t.jn = 4'(j);
          t.angle = chk ? angle : tgt[j];
          t.step = step_cap;
          t.seq = tick_seq;
          t.last = (j == 11);
          pending_targets.push_back(t);
        end
        pub_pose = tgt;
        tick_seq++;
        if (fb_age < 16'hFFFF) fb_age++;
        n_ticks++;
      end
      default: ;
    endcase
  endfunction

  // call at a falling edge; returns at a falling edge
  task automatic send_request(func_e f, bit sit, bit [3:0] jn, bit [15:0] pos,
                              bit chk = 0, bit [15:0] angle = 0);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= f;
    s_axis_tdata_i  <= {3'b000, pos, jn, sit};
    do @(posedge clk_i); while (!s_axis_tready_o);
    apply_request(f, sit, jn, pos, chk, angle);
    if (f != FUNC_NONE && !(f == FUNC_FEEDBACK && jn >= 12)) n_items++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_targets.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SIT_0_3:    sit_word[0] = val;
      CFG_SIT_4_7:    sit_word[1] = val;
      CFG_SIT_8_11:   sit_word[2] = val;
      CFG_TRANSITION: blend_len = 32'(val[15:0]);
      CFG_TIMEOUT:    fresh_limit = 32'(val[15:0]);
      CFG_MAX_STEP:   step_cap = val[14:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_frame(bit broken);
    int skip;
    skip = broken ? int'($urandom_range(11)) : -1;
    for (int j = 0; j < 12; j++)
      if (j != skip)
        send_request(FUNC_FEEDBACK, 1'($urandom_range(1)), 4'(j), 16'($urandom));
  endtask

  always @(negedge clk_i)
    m_axis_tready_i <= (recv_idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    target_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_results++;
      if (pending_targets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", m_axis_tdata_o);
      end else begin
        e = pending_targets.pop_front();
        if (m_axis_tdata_o[3:0] !== e.jn || m_axis_tdata_o[19:4] !== e.angle ||
            m_axis_tdata_o[34:20] !== e.step || m_axis_tdata_o[50:35] !== e.seq ||
            m_axis_tlast_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp joint %0d angle %h step %h seq %0d last %b, got %0d %h %h %0d %b",
                     e.jn, e.angle, e.step, e.seq, e.last, m_axis_tdata_o[3:0],
                     m_axis_tdata_o[19:4], m_axis_tdata_o[34:20], m_axis_tdata_o[50:35],
                     m_axis_tlast_o);
        end
      end
    end
  end

  // watchdog: stop if nothing moves on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= 20000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    bit [15:0] extreme_pos[12];
    int unsigned roll, idle_sel;
    logic [63:0] sit_val;
    sit_word = '{default: '0};
    blend_len = TRANSITION_RESET;
    fresh_limit = TIMEOUT_RESET;
    step_cap = MAX_STEP_RESET;
    sit_on = 0; blending = 0; elapsed = 0; fb_age = 0; tick_seq = 0; fb_ok = 0;
    start_pose = '{default: '0};
    pub_pose = '{default: '0};
    fb_pose = '{default: '0};
    extreme_pos = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555,
                    16'hAAAA, 16'h1000, 16'hF000, 16'h0FFF, 16'h8001, 16'h7FFE};

    // reset state: the first tick's targets all read zero
    dir_rows.push_back('{FUNC_TICK, 0, 0, 0, 1, 16'h0000});
    dir_rows.push_back('{FUNC_NONE, 1, 4'hF, 16'hFFFF, 0, 0});
    dir_rows.push_back('{FUNC_FEEDBACK, 0, 4'd12, 16'h1234, 0, 0});
    dir_rows.push_back('{FUNC_FEEDBACK, 1, 4'd15, 16'h8000, 0, 0});
    dir_rows.push_back('{FUNC_MODE, 0, 0, 0, 0, 0});
    for (int j = 0; j < 12; j++)
      dir_rows.push_back('{FUNC_FEEDBACK, 0, 4'(j), extreme_pos[j], 0, 0});
    dir_rows.push_back('{FUNC_TICK, 0, 0, 0, 0, 0});
    dir_rows.push_back('{FUNC_MODE, 1, 0, 0, 0, 0});
    dir_rows.push_back('{FUNC_TICK, 0, 0, 0, 0, 0});
    dir_rows.push_back('{FUNC_MODE, 1, 0, 0, 0, 0});
    dir_rows.push_back('{FUNC_TICK, 0, 0, 0, 0, 0});
    dir_rows.push_back('{FUNC_MODE, 0, 0, 0, 0, 0});
    dir_rows.push_back('{FUNC_MODE, 0, 0, 0, 0, 0});
    dir_rows.push_back('{FUNC_TICK, 0, 0, 0, 0, 0});

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_request(dir_rows[i].f, dir_rows[i].sit, dir_rows[i].jn, dir_rows[i].pos,
                   dir_rows[i].chk, dir_rows[i].angle);

    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          sit_val = 64'h8000_8000_8000_8000;
          for (int k = 0; k < 3; k++) write_reg(cfg_idx_e'(CFG_SIT_0_3 + k), sit_val);
          write_reg(CFG_TRANSITION, 64'd0);
          write_reg(CFG_TIMEOUT, 64'd0);
          write_reg(CFG_MAX_STEP, 64'd0);
        end
        1: begin
          sit_val = 64'h7FFF_7FFF_7FFF_7FFF;
          for (int k = 0; k < 3; k++) write_reg(cfg_idx_e'(CFG_SIT_0_3 + k), sit_val);
          write_reg(CFG_TRANSITION, 64'hFFFF);
          write_reg(CFG_TIMEOUT, 64'hFFFF);
          write_reg(CFG_MAX_STEP, 64'h7FFF);
        end
        default: begin
          for (int k = 0; k < 3; k++)
            write_reg(cfg_idx_e'(CFG_SIT_0_3 + k), {$urandom, $urandom});
          write_reg(CFG_TRANSITION, 64'((ph == 6) ? $urandom : $urandom_range(1, 12)));
          write_reg(CFG_TIMEOUT, 64'($urandom_range(0, 6)));
          write_reg(CFG_MAX_STEP, 64'($urandom_range(0, 32767)));
        end
      endcase
      idle_sel = ph % 5;
      send_idle_pct = (idle_sel == 1) ? 53 : (idle_sel == 3) ? 33 : 0;
      recv_idle_pct = (idle_sel == 2) ? 53 : (idle_sel == 3) ? 33 : 0;
      while (n_items < 40 + 50 * (ph + 1)) begin
        roll = $urandom_range(99);
        if (roll < 40)
          send_request(FUNC_TICK, 1'($urandom_range(1)), 4'($urandom), 16'($urandom));
        else if (roll < 55)
          send_request(FUNC_MODE, 1'($urandom_range(1)), 4'($urandom), 16'($urandom));
        else if (roll < 80) send_frame($urandom_range(9) == 0);
        else if (roll < 92)
          send_request(FUNC_FEEDBACK, 1'($urandom_range(1)), 4'($urandom_range(15)),
                       16'($urandom));
        else if (roll < 97)
          send_request(FUNC_NONE, 1'($urandom_range(1)), 4'($urandom), 16'($urandom));
        else begin
          // hold off until every target has come out
          s_axis_tvalid_i <= 1'b0;
          @(negedge clk_i);
          while (pending_targets.size() != 0) @(negedge clk_i);
        end
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending_targets.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    $display("Covered %0d requests, %0d ticks (%0d mid-blend), %0d targets checked",
             n_items, n_ticks, n_blend, n_results);
    $display("over 7 register settings and four idle patterns; %0d mismatches", mismatches);
    if (mismatches == 0 && pending_targets.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
